// ----- rtl/pcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pcp_pkg;

    localparam int ARG_CAPACITY = 256;
    localparam int CNT_W        = (ARG_CAPACITY > 2) ? $clog2(ARG_CAPACITY) : 1;
    localparam int CMD_LEN      = 5;
    localparam int MIDX_W       = 3;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        PH_AWAIT_USER = 3'd0,
        PH_USER_ARG   = 3'd1,
        PH_AWAIT_PASS = 3'd2,
        PH_PASS_ARG   = 3'd3,
        PH_ERROR      = 3'd4,
        PH_DONE       = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0] phase_after;
        logic       data_valid;
        logic       data_kind;
        logic [7:0] data_out;
        logic       field_end;
        logic       overflow;
    } pcp_res_t;

    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A)
        begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    // Command characters: pass_sel 0 selects "USER ", 1 selects "PASS "
    function automatic logic [7:0] cmd_char(input logic pass_sel, input logic [MIDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = pass_sel ? 8'h50 : 8'h55;
            3'd1:    c = pass_sel ? 8'h41 : 8'h53;
            3'd2:    c = pass_sel ? 8'h53 : 8'h45;
            3'd3:    c = pass_sel ? 8'h53 : 8'h52;
            3'd4:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pcp_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcp_in_reg
    import pcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       take,
    output logic            hold_valid,
    output logic [7:0]      hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (valid_reg && !take) || in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

`default_nettype wire

// ----- rtl/pcp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcp_core
    import pcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic [7:0] in_byte,
    output pcp_res_t        res
);

    phase_t             phase_reg, phase_next;
    logic [MIDX_W-1:0]  midx_reg, midx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               user_seen_reg, user_seen_next;

    logic       pass_sel;
    logic       hit;
    phase_t     idle_phase;
    phase_t     report;

    assign pass_sel   = (phase_reg == PH_AWAIT_PASS);
    assign hit        = (midx_reg < MIDX_W'(CMD_LEN))
                        && (fold_upper(in_byte) == cmd_char(pass_sel, midx_reg));
    assign idle_phase = user_seen_reg ? PH_AWAIT_PASS : PH_AWAIT_USER;

    always_comb
    begin
        phase_next     = phase_reg;
        midx_next      = midx_reg;
        cnt_next       = cnt_reg;
        user_seen_next = user_seen_reg;
        report         = phase_reg;
        res            = '0;

        unique case (phase_reg)
            PH_AWAIT_USER, PH_AWAIT_PASS:
            begin
                if (hit)
                begin
                    if (midx_reg == MIDX_W'(CMD_LEN - 1))
                    begin
                        midx_next  = '0;
                        phase_next = pass_sel ? PH_PASS_ARG : PH_USER_ARG;
                    end
                    else
                    begin
                        midx_next = midx_reg + 1'b1;
                    end
                end
                else
                begin
                    midx_next  = '0;
                    phase_next = idle_phase;
                end
                report = phase_next;
            end
            PH_USER_ARG, PH_PASS_ARG:
            begin
                res.data_kind = (phase_reg == PH_PASS_ARG);
                priority if (cnt_reg == CNT_W'(ARG_CAPACITY - 1))
                begin
                    res.overflow = 1'b1;
                    cnt_next     = '0;
                    phase_next   = PH_ERROR;
                    report       = PH_ERROR;
                end
                else if (in_byte == CHAR_NEWLINE)
                begin
                    res.field_end = 1'b1;
                    cnt_next      = '0;
                    if (phase_reg == PH_USER_ARG)
                    begin
                        user_seen_next = 1'b1;
                        phase_next     = PH_AWAIT_PASS;
                        report         = PH_AWAIT_PASS;
                    end
                    else
                    begin
                        // pair complete: back to reset state
                        user_seen_next = 1'b0;
                        midx_next      = '0;
                        phase_next     = PH_AWAIT_USER;
                        report         = PH_DONE;
                    end
                end
                else
                begin
                    res.data_valid = 1'b1;
                    res.data_out   = in_byte;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            PH_ERROR:
            begin
                midx_next  = '0;
                phase_next = idle_phase;
                report     = idle_phase;
            end
            default:
            begin
                phase_next = PH_AWAIT_USER;
                midx_next  = '0;
                cnt_next   = '0;
                report     = PH_AWAIT_USER;
            end
        endcase

        res.phase_after = report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_AWAIT_USER;
            midx_reg      <= '0;
            cnt_reg       <= '0;
            user_seen_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            midx_reg      <= midx_next;
            cnt_reg       <= cnt_next;
            user_seen_reg <= user_seen_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pop3_credential_capture_parser_unit.sv -----
// POP3 credential capture parser.
// Input channel in_valid/in_ready carries one client byte (in_byte) per request.
// The parser looks for "USER " (case-insensitive), passes the argument bytes out
// as username data up to a newline, then does the same for "PASS " as password.
// Output channel out_valid/out_ready carries one result per input byte:
// phase_after, data_valid, data_kind, data_out, field_end, overflow.
// Path: an accepted byte waits in the input register until the result register is
// free; its result is then registered there and offered on the output.
// Throughput: one byte per cycle while out_ready stays high, set by the
// parser state update between the input register and the result register.
// Stall: when out_ready is low the result register holds, the input register
// fills, and in_ready drops once both are occupied; nothing is lost.
// Reset (rst_n low, asynchronous): both registers empty, parser awaits USER.
`timescale 1ns / 1ps
`default_nettype none

module pop3_credential_capture_parser_unit
    import pcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      phase_after,
    output logic            data_valid,
    output logic            data_kind,
    output logic [7:0]      data_out,
    output logic            field_end,
    output logic            overflow
);

    logic       hold_valid;
    logic [7:0] hold_byte;
    logic       out_free;
    logic       step_en;
    pcp_res_t   step_res;
    pcp_res_t   res_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign out_free = !out_valid_reg || out_ready;
    assign step_en  = hold_valid && out_free;

    pcp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .take       (step_en),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    pcp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .in_byte (hold_byte),
        .res     (step_res)
    );

    assign out_valid_next = hold_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign phase_after = res_reg.phase_after;
    assign data_valid  = res_reg.data_valid;
    assign data_kind   = res_reg.data_kind;
    assign data_out    = res_reg.data_out;
    assign field_end   = res_reg.field_end;
    assign overflow    = res_reg.overflow;

endmodule

`default_nettype wire

// ----- sim/pcp_result_checker.sv -----
`timescale 1ns / 1ps

module pcp_result_checker
    import pcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] phase_after,
    input  logic       data_valid,
    input  logic       data_kind,
    input  logic [7:0] data_out,
    input  logic       field_end,
    input  logic       overflow,
    output int         errors,
    output int         pending
);

    localparam logic [39:0] USER_WORD = "USER ";
    localparam logic [39:0] PASS_WORD = "PASS ";

    phase_t      cur_phase;
    logic [2:0]  cmd_pos;
    int unsigned arg_len;
    logic        got_user;
    pcp_res_t    expected_q[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
        begin
            $display("%0t checker: %s got %0d want %0d", $time, what, got, want);
        end
        errors++;
    endtask

    // Parser state advance for one client byte; returns the result it should emit.
    function automatic pcp_res_t parse_byte(input logic [7:0] b);
        pcp_res_t    r;
        logic [7:0]  up;
        logic [39:0] word;
        phase_t      rest_phase;
        r = '0;
        rest_phase = got_user ? PH_AWAIT_PASS : PH_AWAIT_USER;
        case (cur_phase)
            PH_AWAIT_USER, PH_AWAIT_PASS:
            begin
                word = (cur_phase == PH_AWAIT_PASS) ? PASS_WORD : USER_WORD;
                up = (b >= "a" && b <= "z") ? b - 8'h20 : b;
                if (cmd_pos < CMD_LEN && up == word[8*(CMD_LEN-1-cmd_pos) +: 8])
                begin
                    if (cmd_pos == CMD_LEN - 1)
                    begin
                        cmd_pos = '0;
                        cur_phase = (cur_phase == PH_AWAIT_PASS) ? PH_PASS_ARG : PH_USER_ARG;
                    end
                    else
                    begin
                        cmd_pos++;
                    end
                end
                else
                begin
                    // mismatching byte is dropped, not taken as a new start
                    cmd_pos = '0;
                    cur_phase = rest_phase;
                end
                r.phase_after = cur_phase;
            end
            PH_USER_ARG, PH_PASS_ARG:
            begin
                r.data_kind = (cur_phase == PH_PASS_ARG);
                if (arg_len + 1 == ARG_CAPACITY)
                begin
                    // capacity check wins over the newline
                    r.overflow = 1'b1;
                    arg_len = 0;
                    cur_phase = PH_ERROR;
                    r.phase_after = PH_ERROR;
                end
                else if (b == CHAR_NEWLINE)
                begin
                    r.field_end = 1'b1;
                    arg_len = 0;
                    if (!r.data_kind)
                    begin
                        got_user = 1'b1;
                        cur_phase = PH_AWAIT_PASS;
                        r.phase_after = PH_AWAIT_PASS;
                    end
                    else
                    begin
                        r.phase_after = PH_DONE;
                        cur_phase = PH_AWAIT_USER;
                        cmd_pos = '0;
                        got_user = 1'b0;
                    end
                end
                else
                begin
                    r.data_valid = 1'b1;
                    r.data_out = b;
                    arg_len++;
                    r.phase_after = cur_phase;
                end
            end
            PH_ERROR:
            begin
                cmd_pos = '0;
                cur_phase = rest_phase;
                r.phase_after = cur_phase;
            end
            default:
            begin
                cur_phase = PH_AWAIT_USER;
                cmd_pos = '0;
                arg_len = 0;
                r.phase_after = cur_phase;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pcp_res_t want;
        if (!rst_n)
        begin
            cur_phase = PH_AWAIT_USER;
            cmd_pos = '0;
            arg_len = 0;
            got_user = 1'b0;
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no request pending, phase_after",
                                    phase_after, -1);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (phase_after !== want.phase_after)
                        report_mismatch("phase_after", phase_after, want.phase_after);
                    if (data_valid !== want.data_valid)
                        report_mismatch("data_valid", data_valid, want.data_valid);
                    if (data_kind !== want.data_kind)
                        report_mismatch("data_kind", data_kind, want.data_kind);
                    if (data_out !== want.data_out)
                        report_mismatch("data_out", data_out, want.data_out);
                    if (field_end !== want.field_end)
                        report_mismatch("field_end", field_end, want.field_end);
                    if (overflow !== want.overflow)
                        report_mismatch("overflow", overflow, want.overflow);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(parse_byte(in_byte));
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import pcp_pkg::*;

    localparam logic [39:0] USER_WORD  = "USER ";
    localparam logic [39:0] PASS_WORD  = "PASS ";
    localparam int          STALL_LIMIT = 1000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] phase_after;
    logic       data_valid;
    logic       data_kind;
    logic [7:0] data_out;
    logic       field_end;
    logic       overflow;

    int errors;
    int pending;
    int sender_pct = 0;
    int stall_pct  = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    pop3_credential_capture_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phase_after (phase_after),
        .data_valid  (data_valid),
        .data_kind   (data_kind),
        .data_out    (data_out),
        .field_end   (field_end),
        .overflow    (overflow)
    );

    pcp_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phase_after (phase_after),
        .data_valid  (data_valid),
        .data_kind   (data_kind),
        .data_out    (data_out),
        .field_end   (field_end),
        .overflow    (overflow),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // first count characters of a command word, letters in random case
    task automatic send_cmd(input logic [39:0] word, input int count);
        logic [7:0] c;
        for (int i = 0; i < count; i++)
        begin
            c = word[8*(CMD_LEN-1-i) +: 8];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
            begin
                c = c + 8'h20;
            end
            send_byte(c);
        end
    endtask

    // argument content: random bytes, never a newline
    task automatic send_arg(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_NEWLINE)
            begin
                b = 8'hF5;
            end
            send_byte(b);
        end
    endtask

    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: byte extremes, case folding edges, no re-scan after mismatch
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("uSe{");
        send_text("uSeR ");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h60);
        send_byte(CHAR_NEWLINE);
        send_text("PPASS ");
        send_text("pass \n");

        // longest argument that fits, then overflow with the newline dropped, error recovery
        sender_pct <= 7;
        stall_pct  <= 7;
        send_text("USER ");
        send_arg(ARG_CAPACITY - 2);
        send_byte(CHAR_NEWLINE);
        send_text("PASS ");
        send_arg(ARG_CAPACITY - 1);
        send_byte(CHAR_NEWLINE);
        send_noise(1);
        send_text("PASS x\n");

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_pct <= 0;
                    stall_pct  <= 0;
                end
                1:
                begin
                    sender_pct <= 75;
                    stall_pct  <= 0;
                end
                2:
                begin
                    sender_pct <= 0;
                    stall_pct  <= 75;
                end
                default:
                begin
                    sender_pct <= 7;
                    stall_pct  <= 7;
                end
            endcase
            target = bytes_sent + 50;
            while (bytes_sent < target)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        send_noise($urandom_range(1, 8));
                    end
                    1:
                    begin
                        send_cmd($urandom_range(0, 1) ? PASS_WORD : USER_WORD,
                                 $urandom_range(1, CMD_LEN - 1));
                        send_noise(1);
                    end
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0)
                            send_noise($urandom_range(1, 3));
                        send_cmd(USER_WORD, CMD_LEN);
                        send_arg($urandom_range(0, 12));
                        send_byte(CHAR_NEWLINE);
                        if ($urandom_range(0, 3) == 0)
                            send_noise($urandom_range(1, 3));
                        send_cmd(PASS_WORD, CMD_LEN);
                        send_arg($urandom_range(0, 12));
                        send_byte(CHAR_NEWLINE);
                    end
                endcase
            end
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (10) @(negedge clk);
        if (errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pcp_pkg.sv
rtl/pcp_in_reg.sv
rtl/pcp_core.sv
rtl/pop3_credential_capture_parser_unit.sv
sim/pcp_result_checker.sv
sim/testbench.sv
